// ===== rtl/core/grid_point_reorder_assert.svh =====
// assertion macros of the grid point reorder checker
`ifndef GRID_POINT_REORDER_ASSERT_SVH
`define GRID_POINT_REORDER_ASSERT_SVH

// same-cycle implication, reset masks the check
`define GPR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// next-cycle implication, reset masks the check
`define GPR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

// ===== rtl/core/gpr_pkg.sv =====
// shared types and constants of the grid point reorder block
`default_nettype none

package gpr_pkg;

   localparam int COORD_W        = 16;
   localparam int CFG_W          = 6;
   localparam int MODE_W         = 3;
   localparam int CNT_W          = 7;
   localparam int PROD_W         = 2 * CFG_W;
   localparam int INDEX_W        = 6;
   localparam int DEF_MAX_POINTS = 64;

   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int REQ_TDATA_W = 2 * COORD_W;
   localparam int RSP_TDATA_W = 40;

   localparam logic [CFG_W-1:0]  GRID_COLS_RST    = 6'd9;
   localparam logic [CFG_W-1:0]  GRID_ROWS_RST    = 6'd6;
   localparam logic [MODE_W-1:0] REORDER_MODE_RST = 3'd0;

   // register indexes, byte address is 4 * index
   localparam logic [1:0] REG_GRID_COLS    = 2'd0;
   localparam logic [1:0] REG_GRID_ROWS    = 2'd1;
   localparam logic [1:0] REG_REORDER_MODE = 2'd2;

   localparam logic [MODE_W-1:0] MODE_NONE   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_FLIP_H = 3'd1;
   localparam logic [MODE_W-1:0] MODE_FLIP_V = 3'd2;
   localparam logic [MODE_W-1:0] MODE_ROT90  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_ROT180 = 3'd4;
   localparam logic [MODE_W-1:0] MODE_ROT270 = 3'd5;

   typedef struct packed {
      logic                  is_error;
      logic [MODE_W-1:0]     mode;
      logic [CFG_W-1:0]      rows;
      logic [CFG_W-1:0]      cols;
      logic [CNT_W-1:0]      total;
   } cmd_type;

   typedef enum logic {
      BK_IDLE,
      BK_RUN
   } bk_state_type;

endpackage

`default_nettype wire

// ===== rtl/core/grid_point_reorder.sv =====
// grid point reorder: top level with configuration registers
//
// Points of a grid come in on the req_ stream in row-major order, one per beat.
// grid_cols, grid_rows and reorder_mode are to be set over the csr_ port only
// while the block is idle; the block itself does not enforce this. Once
// grid_rows * grid_cols points are held, the whole grid goes out on the rsp_
// stream in the chosen order, tlast on the final point. A grid that is empty
// or larger than MAX_POINTS answers every input beat with one error beat
// (tuser high, tlast high, data zero) and stores nothing. Loading takes one
// point per cycle while req_tready is high. Emitting a point takes a store read
// with registered data, then the result register; no store read is issued
// while one is pending. The input is held off from the last point of a grid
// until the last store read of its run is issued. A stalled rsp_ side holds
// the result register and the emitter behind it. Once the last store read of
// a run is issued the loader takes points for the next grid, and holds off
// again when that grid is complete or when two error beats wait in the
// two-entry command queue. Reset sets the registers to 9 columns, 6 rows, no
// reordering, and drops any partly loaded grid; the store itself is not cleared.
`default_nettype none

module grid_point_reorder
   import gpr_pkg::*;
#(
   parameter int MAX_POINTS = DEF_MAX_POINTS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // req_tdata: x_coord [15:0], y_coord [31:16]
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // rsp_tdata: out_x [15:0], out_y [31:16], out_index [37:32], zero fill
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                        rsp_tlast,
   // rsp_tuser: size_error [0]
   output logic                        rsp_tuser,
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]       csr_prdata,
   output logic                        csr_pready
);

   localparam int AW = $clog2(MAX_POINTS);

   logic [CFG_W-1:0]  grid_cols_ff, grid_cols_in;
   logic [CFG_W-1:0]  grid_rows_ff, grid_rows_in;
   logic [MODE_W-1:0] reorder_mode_ff, reorder_mode_in;
   logic              csr_wr;
   logic [1:0]        csr_reg;

   logic                   ram_wr_en;
   logic [AW-1:0]          ram_wr_addr;
   logic [REQ_TDATA_W-1:0] ram_wr_data;
   logic                   ram_rd_en;
   logic [AW-1:0]          ram_rd_addr;
   logic [REQ_TDATA_W-1:0] ram_rd_data;
   logic                   cmd_push;
   logic                   cmd_pop;
   logic                   cmd_full;
   logic                   cmd_empty;
   cmd_type                cmd_wr;
   cmd_type                cmd_rd;
   logic                   run_done;
   logic [COORD_W-1:0]     out_x;
   logic [COORD_W-1:0]     out_y;
   logic [INDEX_W-1:0]     out_index;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_reg    = csr_paddr[3:2];

   always_comb begin
      grid_cols_in    = grid_cols_ff;
      grid_rows_in    = grid_rows_ff;
      reorder_mode_in = reorder_mode_ff;
      if (csr_wr) begin
         case (csr_reg)
            REG_GRID_COLS:    grid_cols_in    = csr_pwdata[CFG_W-1:0];
            REG_GRID_ROWS:    grid_rows_in    = csr_pwdata[CFG_W-1:0];
            REG_REORDER_MODE: reorder_mode_in = csr_pwdata[MODE_W-1:0];
            default:          grid_cols_in    = grid_cols_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_reg)
         REG_GRID_COLS:    csr_prdata = CSR_DATA_W'(grid_cols_ff);
         REG_GRID_ROWS:    csr_prdata = CSR_DATA_W'(grid_rows_ff);
         REG_REORDER_MODE: csr_prdata = CSR_DATA_W'(reorder_mode_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_cols_ff    <= GRID_COLS_RST;
         grid_rows_ff    <= GRID_ROWS_RST;
         reorder_mode_ff <= REORDER_MODE_RST;
      end else begin
         grid_cols_ff    <= grid_cols_in;
         grid_rows_ff    <= grid_rows_in;
         reorder_mode_ff <= reorder_mode_in;
      end
   end

   gpr_front #(
      .MAX_POINTS (MAX_POINTS),
      .AW         (AW)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .grid_cols    (grid_cols_ff),
      .grid_rows    (grid_rows_ff),
      .reorder_mode (reorder_mode_ff),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .run_done     (run_done),
      .ram_wr_en    (ram_wr_en),
      .ram_wr_addr  (ram_wr_addr),
      .ram_wr_data  (ram_wr_data),
      .cmd_push     (cmd_push),
      .cmd_out      (cmd_wr),
      .cmd_full     (cmd_full)
   );

   gpr_cmd_fifo u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd_wr),
      .full     (cmd_full),
      .pop      (cmd_pop),
      .pop_cmd  (cmd_rd),
      .empty    (cmd_empty)
   );

   gpr_ram #(
      .WIDTH (REQ_TDATA_W),
      .DEPTH (MAX_POINTS),
      .AW    (AW)
   ) u_point_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   gpr_back #(
      .MAX_POINTS (MAX_POINTS),
      .AW         (AW)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_in      (cmd_rd),
      .cmd_empty   (cmd_empty),
      .cmd_pop     (cmd_pop),
      .run_done    (run_done),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_x       (out_x),
      .out_y       (out_y),
      .out_index   (out_index),
      .out_last    (rsp_tlast),
      .out_error   (rsp_tuser)
   );

   assign rsp_tdata = {(RSP_TDATA_W - 2 * COORD_W - INDEX_W)'(0), out_index, out_y, out_x};

endmodule

`default_nettype wire

// ===== rtl/core/gpr_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none

module gpr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/gpr_cmd_fifo.sv =====
// two-entry command queue between the loader and the emitter
`default_nettype none

module gpr_cmd_fifo
   import gpr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  cmd_type      push_cmd,
   output logic         full,
   input  wire logic    pop,
   output cmd_type      pop_cmd,
   output logic         empty
);

   cmd_type    slot_ff [2];
   cmd_type    slot_in [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      slot_in   = slot_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         slot_in[wr_ptr_ff] = push_cmd;
         wr_ptr_in          = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign pop_cmd = slot_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ===== rtl/core/gpr_front.sv =====
// loader: accepts points, checks the grid size, writes the store, queues runs
`default_nettype none

module gpr_front
   import gpr_pkg::*;
#(
   parameter int MAX_POINTS = DEF_MAX_POINTS,
   parameter int AW         = $clog2(MAX_POINTS)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [CFG_W-1:0]       grid_cols,
   input  wire logic [CFG_W-1:0]       grid_rows,
   input  wire logic [MODE_W-1:0]      reorder_mode,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   input  wire logic                   run_done,
   output logic                        ram_wr_en,
   output logic [AW-1:0]               ram_wr_addr,
   output logic [REQ_TDATA_W-1:0]      ram_wr_data,
   output logic                        cmd_push,
   output cmd_type                     cmd_out,
   input  wire logic                   cmd_full
);

   logic [CNT_W-1:0]  load_count_ff, load_count_in;
   logic              run_busy_ff, run_busy_in;
   logic [PROD_W-1:0] prod;
   logic              bad_size;
   logic [CNT_W-1:0]  total;
   logic [CNT_W-1:0]  slot;
   logic [CNT_W-1:0]  slot_next;
   logic              accept;

   assign prod     = PROD_W'(grid_rows) * PROD_W'(grid_cols);
   assign bad_size = (prod == '0) || (prod > PROD_W'(MAX_POINTS));
   assign total    = CNT_W'(prod);

   assign req_tready = !run_busy_ff && !cmd_full;
   assign accept     = req_tvalid && req_tready;

   // a grid shrunk below the points already held restarts from zero
   assign slot      = (load_count_ff >= total) ? '0 : load_count_ff;
   assign slot_next = slot + CNT_W'(1);

   always_comb begin
      load_count_in  = load_count_ff;
      run_busy_in    = run_busy_ff;
      ram_wr_en      = 1'b0;
      cmd_push       = 1'b0;
      cmd_out.is_error = bad_size;
      cmd_out.mode     = reorder_mode;
      cmd_out.rows     = grid_rows;
      cmd_out.cols     = grid_cols;
      cmd_out.total    = total;
      if (run_done) begin
         run_busy_in = 1'b0;
      end
      if (accept) begin
         if (bad_size) begin
            load_count_in = '0;
            cmd_push      = 1'b1;
         end else begin
            ram_wr_en = 1'b1;
            if (slot_next == total) begin
               load_count_in = '0;
               cmd_push      = 1'b1;
               run_busy_in   = 1'b1;
            end else begin
               load_count_in = slot_next;
            end
         end
      end
   end

   assign ram_wr_addr = AW'(slot);
   assign ram_wr_data = req_tdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff <= '0;
         run_busy_ff   <= 1'b0;
      end else begin
         load_count_ff <= load_count_in;
         run_busy_ff   <= run_busy_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/gpr_back.sv =====
// emitter: walks the output order, reads the store and drives the result register
`default_nettype none

module gpr_back
   import gpr_pkg::*;
#(
   parameter int MAX_POINTS = DEF_MAX_POINTS,
   parameter int AW         = $clog2(MAX_POINTS)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  cmd_type                     cmd_in,
   input  wire logic                   cmd_empty,
   output logic                        cmd_pop,
   output logic                        run_done,
   output logic                        ram_rd_en,
   output logic [AW-1:0]               ram_rd_addr,
   input  wire logic [REQ_TDATA_W-1:0] ram_rd_data,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output logic [COORD_W-1:0]          out_x,
   output logic [COORD_W-1:0]          out_y,
   output logic [INDEX_W-1:0]          out_index,
   output logic                        out_last,
   output logic                        out_error
);

   bk_state_type      state_ff, state_in;
   cmd_type           run_ff, run_in;
   logic [CFG_W-1:0]  outer_ff, outer_in;
   logic [CFG_W-1:0]  inner_ff, inner_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic              rd_ff, rd_in;
   logic [INDEX_W-1:0] rd_index_ff, rd_index_in;
   logic              rd_last_ff, rd_last_in;
   logic              out_valid_ff, out_valid_in;
   logic [COORD_W-1:0] out_x_ff, out_x_in;
   logic [COORD_W-1:0] out_y_ff, out_y_in;
   logic [INDEX_W-1:0] out_index_ff, out_index_in;
   logic              out_last_ff, out_last_in;
   logic              out_error_ff, out_error_in;

   logic              out_free;
   logic              issue;
   logic              err_load;
   logic              quarter;
   logic              k_last;
   logic [CFG_W-1:0]  inner_lim;
   logic [CFG_W-1:0]  row_sel;
   logic [CFG_W-1:0]  col_sel;
   logic [PROD_W-1:0] src;

   assign out_free = !out_valid_ff || out_ready;
   assign quarter  = (run_ff.mode == MODE_ROT90) || (run_ff.mode == MODE_ROT270);
   assign inner_lim = quarter ? run_ff.rows : run_ff.cols;
   assign k_last   = (k_ff == run_ff.total - CNT_W'(1));

   // source row and column of the point at output position k
   always_comb begin
      case (run_ff.mode)
         MODE_FLIP_H: begin
            row_sel = outer_ff;
            col_sel = run_ff.cols - 6'd1 - inner_ff;
         end
         MODE_FLIP_V: begin
            row_sel = run_ff.rows - 6'd1 - outer_ff;
            col_sel = inner_ff;
         end
         MODE_ROT90: begin
            row_sel = inner_ff;
            col_sel = run_ff.cols - 6'd1 - outer_ff;
         end
         MODE_ROT180: begin
            row_sel = run_ff.rows - 6'd1 - outer_ff;
            col_sel = run_ff.cols - 6'd1 - inner_ff;
         end
         MODE_ROT270: begin
            row_sel = run_ff.rows - 6'd1 - inner_ff;
            col_sel = outer_ff;
         end
         default: begin
            row_sel = outer_ff;
            col_sel = inner_ff;
         end
      endcase
   end

   assign src = PROD_W'(row_sel) * PROD_W'(run_ff.cols) + PROD_W'(col_sel);

   assign issue    = (state_ff == BK_RUN) && !rd_ff && out_free;
   assign err_load = (state_ff == BK_IDLE) && !cmd_empty && cmd_in.is_error
                     && !rd_ff && out_free;
   assign cmd_pop  = (state_ff == BK_IDLE) && !cmd_empty && (!cmd_in.is_error || err_load);
   assign run_done = issue && k_last;

   assign ram_rd_en   = issue;
   assign ram_rd_addr = AW'(src);

   always_comb begin
      state_in     = state_ff;
      run_in       = run_ff;
      outer_in     = outer_ff;
      inner_in     = inner_ff;
      k_in         = k_ff;
      rd_in        = issue;
      rd_index_in  = rd_index_ff;
      rd_last_in   = rd_last_ff;
      out_valid_in = out_valid_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_index_in = out_index_ff;
      out_last_in  = out_last_ff;
      out_error_in = out_error_ff;

      case (state_ff)
         BK_IDLE: begin
            if (cmd_pop && !cmd_in.is_error) begin
               run_in   = cmd_in;
               outer_in = '0;
               inner_in = '0;
               k_in     = '0;
               state_in = BK_RUN;
            end
         end
         BK_RUN: begin
            if (issue) begin
               rd_index_in = INDEX_W'(k_ff);
               rd_last_in  = k_last;
               k_in        = k_ff + CNT_W'(1);
               if (inner_ff == inner_lim - 6'd1) begin
                  inner_in = '0;
                  outer_in = outer_ff + 6'd1;
               end else begin
                  inner_in = inner_ff + 6'd1;
               end
               if (k_last) begin
                  state_in = BK_IDLE;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      // result register; a pending read always finds it free
      if (rd_ff) begin
         out_valid_in = 1'b1;
         out_x_in     = ram_rd_data[COORD_W-1:0];
         out_y_in     = ram_rd_data[REQ_TDATA_W-1:COORD_W];
         out_index_in = rd_index_ff;
         out_last_in  = rd_last_ff;
         out_error_in = 1'b0;
      end else if (err_load) begin
         out_valid_in = 1'b1;
         out_x_in     = '0;
         out_y_in     = '0;
         out_index_in = '0;
         out_last_in  = 1'b1;
         out_error_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      run_ff       <= run_in;
      outer_ff     <= outer_in;
      inner_ff     <= inner_in;
      k_ff         <= k_in;
      rd_index_ff  <= rd_index_in;
      rd_last_ff   <= rd_last_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_index_ff <= out_index_in;
      out_last_ff  <= out_last_in;
      out_error_ff <= out_error_in;
      if (reset) begin
         state_ff     <= BK_IDLE;
         rd_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_ff        <= rd_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_x     = out_x_ff;
   assign out_y     = out_y_ff;
   assign out_index = out_index_ff;
   assign out_last  = out_last_ff;
   assign out_error = out_error_ff;

endmodule

`default_nettype wire

// ===== rtl/core/gpr_checker.sv =====
// port-level checks of the grid point reorder block, bound to the top level
`default_nettype none

`include "grid_point_reorder_assert.svh"

module gpr_checker
   import gpr_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic [REQ_TDATA_W-1:0] req_tdata,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic                   rsp_tlast,
   input wire logic                   rsp_tuser,
   input wire logic                   csr_psel,
   input wire logic                   csr_penable,
   input wire logic                   csr_pwrite,
   input wire logic [CSR_ADDR_W-1:0]  csr_paddr,
   input wire logic [CSR_DATA_W-1:0]  csr_pwdata,
   input wire logic [CSR_DATA_W-1:0]  csr_prdata,
   input wire logic                   csr_pready
);

   logic rsp_stall;
   logic rsp_beat;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_beat  = rsp_tvalid && rsp_tready;

   // a stalled result beat holds its payload
   `GPR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))

   // an error beat closes its run and carries no point
   `GPR_ASSERT_NOW(a_err_beat, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast && (rsp_tdata == '0))

   // point beats never come back to back: each takes a store read, then the result register
   `GPR_ASSERT_NEXT(a_point_gap, clock, reset, rsp_beat, !rsp_tvalid || rsp_tuser)

endmodule

bind grid_point_reorder gpr_checker u_gpr_checker (.*);

`default_nettype wire

// ===== bench/gpr_order_check.sv =====
`timescale 1ns / 100ps
// checker for the grid point reorder: predicts every reordered run and compares rsp beats
module gpr_order_check
   import gpr_pkg::*;
#(
   parameter int MAX_POINTS = DEF_MAX_POINTS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   rsp_tlast,
   input  logic                   rsp_tuser,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   input  logic                   csr_pready,
   output int                     mismatch_count,
   output int                     owed
);

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [INDEX_W-1:0] idx;
      logic               last;
      logic               err;
   } point_beat_type;

   point_beat_type     owed_points[$];
   point_beat_type     want;
   logic [CFG_W-1:0]   cols_q;
   logic [CFG_W-1:0]   rows_q;
   logic [MODE_W-1:0]  mode_q;
   logic [COORD_W-1:0] x_mem [MAX_POINTS];
   logic [COORD_W-1:0] y_mem [MAX_POINTS];
   logic [CNT_W-1:0]   fill;

   // stored position that output position k of the run is read from
   function automatic int source_of(int k, int rows, int cols, logic [MODE_W-1:0] mode);
      int r;
      int c;
      r = k / cols;
      c = k % cols;
      case (mode)
         MODE_ROT90:  return (k % rows) * cols + (cols - 1 - k / rows);
         MODE_ROT270: return (rows - 1 - k % rows) * cols + k / rows;
         MODE_FLIP_H: return r * cols + (cols - 1 - c);
         MODE_FLIP_V: return (rows - 1 - r) * cols + c;
         MODE_ROT180: return (rows - 1 - r) * cols + (cols - 1 - c);
         default:     return k;
      endcase
   endfunction

   // append one predicted beat at the tail of the owed list
   task automatic append_beat(point_beat_type b);
      owed_points = {owed_points, b};
   endtask

   task automatic take_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      int             total;
      int             s;
      point_beat_type b;
      total = int'(rows_q) * int'(cols_q);
      if (total == 0 || total > MAX_POINTS) begin
         // grid does not fit: point dropped, one error beat
         fill = '0;
         b = '{x: '0, y: '0, idx: '0, last: 1'b1, err: 1'b1};
         append_beat(b);
         return;
      end
      // grid shrunk under a partial load restarts it
      if (int'(fill) >= total)
         fill = '0;
      x_mem[fill] = x;
      y_mem[fill] = y;
      fill = fill + 1'b1;
      if (int'(fill) < total)
         return;
      for (int k = 0; k < total; k++) begin
         s = source_of(k, int'(rows_q), int'(cols_q), mode_q);
         b.x = x_mem[s];
         b.y = y_mem[s];
         b.idx = INDEX_W'(k);
         b.last = (k == total - 1);
         b.err = 1'b0;
         append_beat(b);
      end
      fill = '0;
   endtask

   task automatic report_mismatch(string what, logic [COORD_W-1:0] got,
                                  logic [COORD_W-1:0] exp_val);
      mismatch_count++;
      $display("[%0t] rsp mismatch %s: got %h, predicted %h", $time, what, got, exp_val);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cols_q = GRID_COLS_RST;
         rows_q = GRID_ROWS_RST;
         mode_q = REORDER_MODE_RST;
         fill = '0;
         owed_points.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_ADDR_W-1:2])
               REG_GRID_COLS:    cols_q = csr_pwdata[CFG_W-1:0];
               REG_GRID_ROWS:    rows_q = csr_pwdata[CFG_W-1:0];
               REG_REORDER_MODE: mode_q = csr_pwdata[MODE_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            take_point(req_tdata[15:0], req_tdata[31:16]);
         if (rsp_tvalid && rsp_tready) begin
            if (owed_points.size() == 0) begin
               report_mismatch("beat with nothing owed, out_x", rsp_tdata[15:0], '0);
            end else begin
               want = owed_points.pop_front();
               if (rsp_tdata[15:0] !== want.x)
                  report_mismatch("out_x", rsp_tdata[15:0], want.x);
               if (rsp_tdata[31:16] !== want.y)
                  report_mismatch("out_y", rsp_tdata[31:16], want.y);
               if (rsp_tdata[37:32] !== want.idx)
                  report_mismatch("out_index", rsp_tdata[37:32], want.idx);
               if (rsp_tlast !== want.last)
                  report_mismatch("last_point", rsp_tlast, want.last);
               if (rsp_tuser !== want.err)
                  report_mismatch("size_error", rsp_tuser, want.err);
            end
         end
      end
      owed = owed_points.size();
   end

endmodule

// ===== bench/tb_grid_point_reorder.sv =====
`timescale 1ns / 100ps
// testbench top for the grid point reorder: stimulus, receiver stalls and verdict
module tb_grid_point_reorder;
   import gpr_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE         = 12;
   localparam int ITEM_TARGET    = 280;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   rsp_tuser;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [CSR_DATA_W-1:0]  csr_pwdata;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;
   int                     mismatch_count;
   int                     owed;

   int points_sent;
   bit req_idle_on;
   bit rsp_idle_on;
   int stall_request;
   int quiet_cycles;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   grid_point_reorder dut (.*);

   gpr_order_check check (.*);

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 70)
         return $urandom_range(1, 3);
      else if (p < 95)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic csr_write(logic [1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_grid(int cols, int rows, logic [MODE_W-1:0] mode);
      csr_write(REG_GRID_COLS, CSR_DATA_W'(cols));
      csr_write(REG_GRID_ROWS, CSR_DATA_W'(rows));
      csr_write(REG_REORDER_MODE, CSR_DATA_W'(mode));
   endtask

   task automatic send_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= {y, x};
      do @(posedge clock); while (!req_tready);
      points_sent++;
      if (req_idle_on && $urandom_range(0, 2) == 0) begin
         gap = gap_len();
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_points(int n);
      for (int i = 0; i < n; i++)
         send_point(COORD_W'($urandom), COORD_W'($urandom));
   endtask

   // sender pauses until every owed beat is back, then lets the block settle
   task automatic finish_burst();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (owed != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // receiver: random stalls, or one long hold-off when asked
   initial begin
      int n;
      rsp_tready <= 1'b0;
      wait (!reset);
      forever begin
         if (stall_request > 0) begin
            n = stall_request;
            stall_request = 0;
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end else if (rsp_idle_on && $urandom_range(0, 3) == 0) begin
            n = gap_len();
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int               cols;
      int               rows;
      int               total;
      int               n;
      int               shape;
      int               phase;
      logic [MODE_W-1:0] mode;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      points_sent = 0;
      stall_request = 0;
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // coordinate extremes through a row mirror
      set_grid(3, 2, MODE_FLIP_H);
      send_point(16'h0000, 16'hFFFF);
      send_point(16'hFFFF, 16'h0000);
      send_point(16'h5555, 16'hAAAA);
      send_point(16'hAAAA, 16'h5555);
      send_point(16'h0001, 16'h8000);
      send_point(16'h8000, 16'h0001);
      finish_burst();
      // quarter turns give a cols-by-rows run
      set_grid(3, 2, MODE_ROT90);
      send_points(6);
      finish_burst();
      set_grid(3, 2, MODE_ROT270);
      send_points(6);
      finish_burst();
      // empty grid and oversized grid answer with an error beat
      set_grid(9, 0, MODE_NONE);
      send_points(1);
      finish_burst();
      set_grid(40, 2, MODE_ROT180);
      send_points(1);
      finish_burst();
      // single row
      set_grid(3, 1, MODE_FLIP_V);
      send_points(3);
      finish_burst();
      // partial grid, then shrink below what is loaded
      set_grid(3, 2, MODE_ROT180);
      send_points(3);
      finish_burst();
      set_grid(1, 2, MODE_ROT180);
      send_points(2);
      finish_burst();

      phase = 0;
      while (points_sent < ITEM_TARGET) begin
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         mode = MODE_W'($urandom_range(0, 7));
         if (phase == 3) begin
            // long receiver hold-off while small grids keep coming
            set_grid(2, 2, mode);
            stall_request = HOLD_CYCLES;
            send_points(24);
         end else begin
            shape = $urandom_range(0, 19);
            if (shape == 0) begin
               cols = $urandom_range(0, 1) ? 0 : $urandom_range(0, 63);
               rows = (cols != 0) ? 0 : $urandom_range(0, 63);
            end else if (shape == 1) begin
               cols = $urandom_range(9, 63);
               rows = $urandom_range(9, 63);
            end else if (shape == 2) begin
               case ($urandom_range(0, 5))
                  0: begin cols = 8;  rows = 8;  end
                  1: begin cols = 32; rows = 2;  end
                  2: begin cols = 2;  rows = 32; end
                  3: begin cols = 1;  rows = 63; end
                  4: begin cols = 63; rows = 1;  end
                  default: begin cols = 16; rows = 4; end
               endcase
            end else begin
               cols = $urandom_range(1, 6);
               rows = $urandom_range(1, 6);
            end
            set_grid(cols, rows, mode);
            total = cols * rows;
            if (total == 0 || total > DEF_MAX_POINTS)
               n = $urandom_range(1, 3);
            else if (total > 16)
               n = total;
            else
               n = total * $urandom_range(1, 3);
            // now and then leave a grid partly loaded for the next setting
            if (total > 1 && total <= DEF_MAX_POINTS && $urandom_range(0, 4) == 0)
               n = n + $urandom_range(1, total - 1);
            send_points(n);
         end
         finish_burst();
         phase++;
      end

      repeat (SETTLE) @(posedge clock);
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
